FILE: rtl/qvr_pkg.sv
// Shared types and constants for the quaternion vector rotation block.
package qvr_pkg;

  localparam int QuatWidth   = 16;
  localparam int VecWidth    = 16;
  localparam int ProdWidth   = 2 * QuatWidth;
  localparam int SumWidth    = ProdWidth + 2;
  localparam int CrossWidth  = ProdWidth + 1;
  localparam int TermWidth   = VecWidth + SumWidth;
  localparam int PWidth      = TermWidth + 2;
  localparam int QuotBits    = VecWidth;
  localparam int DenWidth    = SumWidth;
  localparam int NumWidth    = DenWidth + QuotBits + 1;
  localparam int Lanes       = 3;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_SAT  = 2'd1,
    STATUS_ZERO = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [QuatWidth-1:0] quat_w;
    logic signed [QuatWidth-1:0] quat_x;
    logic signed [QuatWidth-1:0] quat_y;
    logic signed [QuatWidth-1:0] quat_z;
    logic signed [VecWidth-1:0]  vec_x;
    logic signed [VecWidth-1:0]  vec_y;
    logic signed [VecWidth-1:0]  vec_z;
  } in_t;

  typedef struct packed {
    logic signed [VecWidth-1:0] rot_x;
    logic signed [VecWidth-1:0] rot_y;
    logic signed [VecWidth-1:0] rot_z;
    status_e                    status;
  } out_t;

  typedef struct packed {
    logic             zero;
    logic [Lanes-1:0] neg;
  } side_t;

endpackage

FILE: rtl/qvr_div.sv
// Pipelined restoring divider, one quotient bit per stage, three lanes sharing a divisor.
module qvr_div #(
  parameter int QuotBits = qvr_pkg::QuotBits,
  parameter int NumWidth = qvr_pkg::NumWidth,
  parameter int DenWidth = qvr_pkg::DenWidth
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         valid_i,
  input  logic [qvr_pkg::Lanes-1:0][NumWidth-1:0]      num_i,
  input  logic [DenWidth-1:0]                          den_i,
  input  qvr_pkg::side_t                               side_i,
  output logic                                         valid_o,
  output logic [qvr_pkg::Lanes-1:0][QuotBits-1:0]      quot_o,
  output qvr_pkg::side_t                               side_o
);

  logic [QuotBits-1:0]                                  valid_q;
  logic [QuotBits-1:0][qvr_pkg::Lanes-1:0][NumWidth-1:0] rem_q;
  logic [QuotBits-1:0][qvr_pkg::Lanes-1:0][QuotBits-1:0] quo_q;
  logic [QuotBits-1:0][DenWidth-1:0]                    den_q;
  qvr_pkg::side_t [QuotBits-1:0]                        side_q;

  logic [QuotBits-1:0][qvr_pkg::Lanes-1:0][NumWidth-1:0] rem_d;
  logic [QuotBits-1:0][qvr_pkg::Lanes-1:0][QuotBits-1:0] quo_d;

  logic                                                 valid_out_q;
  logic [qvr_pkg::Lanes-1:0][QuotBits-1:0]              quot_out_q;
  qvr_pkg::side_t                                       side_out_q;

  always_comb begin
    logic [NumWidth-1:0] trial;
    for (int k = 0; k < QuotBits; k++) begin
      for (int l = 0; l < qvr_pkg::Lanes; l++) begin
        trial = NumWidth'(den_q[k]) << (QuotBits - 1 - k);
        rem_d[k][l] = rem_q[k][l];
        quo_d[k][l] = quo_q[k][l];
        if (rem_q[k][l] >= trial) begin
          rem_d[k][l] = rem_q[k][l] - trial;
          quo_d[k][l][QuotBits-1-k] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      valid_out_q <= 1'b0;
    end else begin
      valid_q     <= {valid_q[QuotBits-2:0], valid_i};
      valid_out_q <= valid_q[QuotBits-1];
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= num_i;
    quo_q[0]  <= '0;
    den_q[0]  <= den_i;
    side_q[0] <= side_i;
    for (int k = 1; k < QuotBits; k++) begin
      rem_q[k]  <= rem_d[k-1];
      quo_q[k]  <= quo_d[k-1];
      den_q[k]  <= den_q[k-1];
      side_q[k] <= side_q[k-1];
    end
    quot_out_q <= quo_d[QuotBits-1];
    side_out_q <= side_q[QuotBits-1];
  end

  assign valid_o = valid_out_q;
  assign quot_o  = quot_out_q;
  assign side_o  = side_out_q;

endmodule

FILE: rtl/quaternion_vector_rotate.sv
// Top level of the quaternion vector rotation pipeline.
// Usage: a beat is taken on in_i at each rising edge where start_i is high and
// busy_o is low. The block holds busy_o low at all times, so a beat may enter
// in every cycle and the sustained rate is one vector per clock.
// Each beat yields exactly one result on res_o, marked by done_o for a single
// cycle. On its way the beat passes through four multiply and add stages,
// sixteen stages of the restoring divider that scales by the squared norm, and
// the divider and saturation output registers.
// Results leave in the order the beats entered. The receiver cannot stall and
// must take every result in the cycle it is shown.
// A zero quaternion gives a zero vector with the zero status. A result that
// exceeds the vector range is clamped and flagged with the saturation status.
// Reset clears all valid bits, so no result appears until a beat is taken.
module quaternion_vector_rotate (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  qvr_pkg::in_t   in_i,
  output logic           done_o,
  output qvr_pkg::out_t  res_o
);

  localparam int QW = qvr_pkg::QuatWidth;
  localparam int VW = qvr_pkg::VecWidth;
  localparam int PW = qvr_pkg::ProdWidth;
  localparam int SW = qvr_pkg::SumWidth;
  localparam int CW = qvr_pkg::CrossWidth;
  localparam int TW = qvr_pkg::TermWidth;
  localparam int XW = qvr_pkg::PWidth;
  localparam int NW = qvr_pkg::NumWidth;
  localparam int DW = qvr_pkg::DenWidth;
  localparam int BW = qvr_pkg::QuotBits;
  localparam int L  = qvr_pkg::Lanes;

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  logic signed [QW-1:0] u_in [L];
  logic signed [VW-1:0] v_in [L];
  assign u_in[0] = in_i.quat_x;
  assign u_in[1] = in_i.quat_y;
  assign u_in[2] = in_i.quat_z;
  assign v_in[0] = in_i.vec_x;
  assign v_in[1] = in_i.vec_y;
  assign v_in[2] = in_i.vec_z;

  // Stage 1: elementary products.
  logic                 v1_q;
  logic signed [PW-1:0] ww1_q;
  logic signed [PW-1:0] uu1_q [L];
  logic signed [PW-1:0] uv1_q [L];
  logic signed [PW-1:0] ca1_q [L];
  logic signed [PW-1:0] cb1_q [L];
  logic signed [QW-1:0] w1_q;
  logic signed [QW-1:0] u1_q [L];
  logic signed [VW-1:0] vv1_q [L];

  always_ff @(posedge clk_i) begin
    ww1_q <= PW'(in_i.quat_w) * PW'(in_i.quat_w);
    w1_q  <= in_i.quat_w;
    for (int l = 0; l < L; l++) begin
      uu1_q[l] <= PW'(u_in[l]) * PW'(u_in[l]);
      uv1_q[l] <= PW'(u_in[l]) * PW'(v_in[l]);
      ca1_q[l] <= PW'(u_in[(l+1)%3]) * PW'(v_in[(l+2)%3]);
      cb1_q[l] <= PW'(u_in[(l+2)%3]) * PW'(v_in[(l+1)%3]);
      u1_q[l]  <= u_in[l];
      vv1_q[l] <= v_in[l];
    end
  end

  // Stage 2: norm, scalar part, dot and cross products.
  logic                 v2_q;
  logic signed [SW-1:0] nsq2_q, s2_q, dot2_q;
  logic signed [CW-1:0] c2_q [L];
  logic signed [QW-1:0] w2_q;
  logic signed [QW-1:0] u2_q [L];
  logic signed [VW-1:0] vv2_q [L];
  logic signed [SW-1:0] uu2;
  assign uu2 = SW'(uu1_q[0]) + SW'(uu1_q[1]) + SW'(uu1_q[2]);

  always_ff @(posedge clk_i) begin
    nsq2_q <= SW'(ww1_q) + uu2;
    s2_q   <= SW'(ww1_q) - uu2;
    dot2_q <= SW'(uv1_q[0]) + SW'(uv1_q[1]) + SW'(uv1_q[2]);
    w2_q   <= w1_q;
    for (int l = 0; l < L; l++) begin
      c2_q[l]  <= CW'(ca1_q[l]) - CW'(cb1_q[l]);
      u2_q[l]  <= u1_q[l];
      vv2_q[l] <= vv1_q[l];
    end
  end

  // Stage 3: the three terms of each component.
  logic                 v3_q;
  logic signed [SW-1:0] nsq3_q;
  logic signed [TW-1:0] vs3_q [L];
  logic signed [TW-1:0] ud3_q [L];
  logic signed [TW-1:0] wc3_q [L];

  always_ff @(posedge clk_i) begin
    nsq3_q <= nsq2_q;
    for (int l = 0; l < L; l++) begin
      vs3_q[l] <= TW'(vv2_q[l]) * TW'(s2_q);
      ud3_q[l] <= TW'(u2_q[l]) * TW'(dot2_q);
      wc3_q[l] <= TW'(w2_q) * TW'(c2_q[l]);
    end
  end

  // Stage 4: component sums.
  logic                 v4_q;
  logic signed [SW-1:0] nsq4_q;
  logic signed [XW-1:0] p4_q [L];

  always_ff @(posedge clk_i) begin
    nsq4_q <= nsq3_q;
    for (int l = 0; l < L; l++) begin
      p4_q[l] <= XW'(vs3_q[l]) + (XW'(ud3_q[l]) <<< 1) + (XW'(wc3_q[l]) <<< 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Rounded division setup: quotient is (2|p| + nsq) / (2 nsq).
  logic [L-1:0][NW-1:0] num;
  logic [DW-1:0]        den;
  qvr_pkg::side_t       side_in;
  logic [XW-1:0]        mag [L];

  always_comb begin
    side_in.zero = (nsq4_q == '0);
    den = DW'({nsq4_q[DW-2:0], 1'b0});
    for (int l = 0; l < L; l++) begin
      side_in.neg[l] = p4_q[l][XW-1];
      mag[l] = p4_q[l][XW-1] ? XW'(-p4_q[l]) : XW'(p4_q[l]);
      num[l] = {mag[l][NW-2:0], 1'b0} + NW'(unsigned'(nsq4_q));
    end
  end

  logic                  dv_valid;
  logic [L-1:0][BW-1:0]  quot;
  qvr_pkg::side_t        side_out;

  qvr_div #(
    .QuotBits(BW),
    .NumWidth(NW),
    .DenWidth(DW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v4_q),
    .num_i   (num),
    .den_i   (den),
    .side_i  (side_in),
    .valid_o (dv_valid),
    .quot_o  (quot),
    .side_o  (side_out)
  );

  // Final stage: sign, saturation and status.
  logic [L-1:0][VW-1:0] rot;
  logic [L-1:0]         sat;
  logic                 done_q;
  qvr_pkg::out_t        res_d, res_q;

  always_comb begin
    for (int l = 0; l < L; l++) begin
      if (side_out.neg[l]) begin
        sat[l] = quot[l] > BW'({1'b1, {(VW-1){1'b0}}});
        rot[l] = sat[l] ? {1'b1, {(VW-1){1'b0}}} : VW'(-quot[l]);
      end else begin
        sat[l] = quot[l] > BW'({1'b0, {(VW-1){1'b1}}});
        rot[l] = sat[l] ? {1'b0, {(VW-1){1'b1}}} : VW'(quot[l]);
      end
    end
    if (side_out.zero) begin
      res_d.rot_x  = '0;
      res_d.rot_y  = '0;
      res_d.rot_z  = '0;
      res_d.status = qvr_pkg::STATUS_ZERO;
    end else begin
      res_d.rot_x  = rot[0];
      res_d.rot_y  = rot[1];
      res_d.rot_z  = rot[2];
      res_d.status = (|sat) ? qvr_pkg::STATUS_SAT : qvr_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
